[rtl/key_matrix_serial_port_macros.svh]
// Assertion macros for the keyboard serial port checker.
// No dependencies; included by the checker file only.
`ifndef KEY_MATRIX_SERIAL_PORT_MACROS_SVH
`define KEY_MATRIX_SERIAL_PORT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KMSP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmsp same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KMSP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmsp next-cycle check failed");

`endif

[rtl/kmsp_pkg.sv]
// Shared types, constants and character tables for the keyboard serial port.
// No dependencies; used by the top level, the decoder and the ring.
`default_nettype none

package kmsp_pkg;

   typedef enum logic [1:0] {
      REQ_SCAN   = 2'd0,
      REQ_DATA   = 2'd1,
      REQ_STATUS = 2'd2,
      REQ_TICK   = 2'd3
   } req_kind_type;

   typedef logic [9:0][7:0] rows_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] push_data;
   } ring_ctl_type;

   typedef struct packed {
      logic       avail;
      logic [7:0] head;
   } ring_stat_type;

   localparam int          NUM_ROWS      = 10;
   localparam int          TAB_SIZE      = 80;
   localparam logic [7:0]  SHIFT_MASK    = 8'h21;
   localparam logic [7:0]  ROW8_KEY_MASK = 8'hde;
   localparam int          SHIFT_ROW     = 8;
   localparam int          CTRL_ROW      = 9;
   localparam int          CTRL_BIT      = 7;
   localparam int          CAPS_ROW      = 6;
   localparam int          CAPS_BIT      = 5;
   localparam logic [7:0]  CTRL_MASK     = 8'h1f;
   localparam logic [7:0]  UPPER_LO      = 8'h41;
   localparam logic [7:0]  UPPER_HI      = 8'h5f;
   localparam logic [7:0]  LOWER_LO      = 8'h61;
   localparam logic [7:0]  LOWER_HI      = 8'h7a;
   localparam logic [7:0]  STATUS_BASE   = 8'h06;
   localparam logic [15:0] TICK_MAX      = 16'hffff;

   localparam logic [7:0] TAB_PLAIN [TAB_SIZE] = '{
      8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2d, 8'h00, 8'h00,
      8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h00, 8'h00, 8'h00,
      8'h71, 8'h65, 8'h74, 8'h75, 8'h6f, 8'h3d, 8'h00, 8'h00,
      8'h77, 8'h72, 8'h79, 8'h69, 8'h70, 8'h00, 8'h00, 8'h00,
      8'h61, 8'h64, 8'h67, 8'h6a, 8'h6c, 8'h00, 8'h00, 8'h00,
      8'h73, 8'h66, 8'h68, 8'h6b, 8'h3b, 8'h00, 8'h00, 8'h00,
      8'h7a, 8'h63, 8'h62, 8'h6d, 8'h2e, 8'h00, 8'h00, 8'h00,
      8'h78, 8'h76, 8'h6e, 8'h2c, 8'h2f, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h08, 8'h00, 8'h0c, 8'h0d, 8'h00, 8'h00, 8'h00,
      8'h1e, 8'h20, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] TAB_SHIFT [TAB_SIZE] = '{
      8'h21, 8'h23, 8'h25, 8'h27, 8'h29, 8'h2b, 8'h00, 8'h00,
      8'h22, 8'h24, 8'h26, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h3c, 8'h00, 8'h5d, 8'h40, 8'h3a, 8'h2a, 8'h00, 8'h00,
      8'h3e, 8'h5b, 8'h5c, 8'h3f, 8'h5e, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h01, 8'h0a, 8'h00, 8'h00, 8'h00,
      8'h1a, 8'h20, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] TAB_CAPS [TAB_SIZE] = '{
      8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2d, 8'h00, 8'h00,
      8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h00, 8'h00, 8'h00,
      8'h51, 8'h45, 8'h54, 8'h55, 8'h4f, 8'h3d, 8'h00, 8'h00,
      8'h57, 8'h52, 8'h59, 8'h49, 8'h50, 8'h00, 8'h00, 8'h00,
      8'h41, 8'h44, 8'h47, 8'h4a, 8'h4c, 8'h00, 8'h00, 8'h00,
      8'h53, 8'h46, 8'h48, 8'h4b, 8'h3b, 8'h00, 8'h00, 8'h00,
      8'h5a, 8'h43, 8'h42, 8'h4d, 8'h2e, 8'h00, 8'h00, 8'h00,
      8'h58, 8'h56, 8'h4e, 8'h2c, 8'h2f, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h08, 8'h00, 8'h0c, 8'h0d, 8'h00, 8'h00, 8'h00,
      8'h1e, 8'h20, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

endpackage

`default_nettype wire

[rtl/key_matrix_serial_port.sv]
// Keyboard serial port: input register, one pass of decode and state update,
// output register; a transfer is decoded once the output register is free.
// One item per cycle unless rsp_ready stalls, set by the single update stage.
// Synchronous active-high reset clears handshake state, ring pointers, caps
// lock, last key, tick count and square bit; ring contents are not cleared.
`default_nettype none

module key_matrix_serial_port #(
   parameter int RING_DEPTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_row_zero,
   input  wire logic [7:0] req_row_one,
   input  wire logic [7:0] req_row_two,
   input  wire logic [7:0] req_row_three,
   input  wire logic [7:0] req_row_four,
   input  wire logic [7:0] req_row_five,
   input  wire logic [7:0] req_row_six,
   input  wire logic [7:0] req_row_seven,
   input  wire logic [7:0] req_row_eight,
   input  wire logic [7:0] req_row_nine,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq_request,
   output logic            rsp_caps_led
);

   logic                    in_valid_ff;
   kmsp_pkg::req_kind_type  req_kind_ff;
   kmsp_pkg::rows_type      rows_ff;
   logic                    fire;

   logic                    rsp_valid_ff;
   logic [7:0]              rsp_data_ff;
   logic [7:0]              rsp_data_in;
   logic                    rsp_irq_ff;
   logic                    rsp_irq_in;

   logic [7:0]              last_char_ff;
   logic [7:0]              last_char_in;
   logic                    last_caps_ff;
   logic                    last_caps_in;
   logic                    caps_lock_ff;
   logic                    caps_lock_in;
   logic [15:0]             tick_count_ff;
   logic [15:0]             tick_count_in;
   logic                    square_ff;
   logic                    square_in;

   logic [7:0]              key_char;
   logic                    caps_key;
   kmsp_pkg::ring_ctl_type  ring_ctl;
   kmsp_pkg::ring_stat_type ring_stat;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_kind_ff <= kmsp_pkg::req_kind_type'(req_type);
         rows_ff     <= {req_row_nine, req_row_eight, req_row_seven, req_row_six,
                         req_row_five, req_row_four, req_row_three, req_row_two,
                         req_row_one, req_row_zero};
      end
   end

   kmsp_decode u_decode (
      .rows      (rows_ff),
      .caps_lock (caps_lock_ff),
      .key_char  (key_char)
   );

   kmsp_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ring_ctl  (ring_ctl),
      .ring_stat (ring_stat)
   );

   assign caps_key = rows_ff[kmsp_pkg::CAPS_ROW][kmsp_pkg::CAPS_BIT];

   always_comb begin
      last_char_in       = last_char_ff;
      last_caps_in       = last_caps_ff;
      caps_lock_in       = caps_lock_ff;
      tick_count_in      = tick_count_ff;
      square_in          = square_ff;
      rsp_data_in        = 8'h00;
      rsp_irq_in         = 1'b0;
      ring_ctl.push      = 1'b0;
      ring_ctl.pop       = 1'b0;
      ring_ctl.push_data = key_char;
      if (fire) begin
         unique case (req_kind_ff)
            kmsp_pkg::REQ_SCAN: begin
               ring_ctl.push = (key_char != last_char_ff) && (key_char != 8'h00);
               last_char_in  = key_char;
               if (caps_key && !last_caps_ff) begin
                  caps_lock_in = !caps_lock_ff;
               end
               last_caps_in = caps_key;
               rsp_irq_in   = ring_ctl.push || (tick_count_ff != 16'h0000);
            end
            kmsp_pkg::REQ_DATA: begin
               if (ring_stat.avail) begin
                  ring_ctl.pop = 1'b1;
                  rsp_data_in  = ring_stat.head;
               end
            end
            kmsp_pkg::REQ_STATUS: begin
               if (tick_count_ff != 16'h0000) begin
                  tick_count_in = tick_count_ff - 16'd1;
                  square_in     = !square_ff;
               end
               rsp_data_in = kmsp_pkg::STATUS_BASE | {7'b0, ring_stat.avail} |
                             {4'b0, square_in, 3'b0};
            end
            kmsp_pkg::REQ_TICK: begin
               if (tick_count_ff != kmsp_pkg::TICK_MAX) begin
                  tick_count_in = tick_count_ff + 16'd1;
               end
            end
            default: begin
               rsp_data_in = 8'h00;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_char_ff  <= '0;
         last_caps_ff  <= 1'b0;
         caps_lock_ff  <= 1'b0;
         tick_count_ff <= '0;
         square_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         last_char_ff  <= last_char_in;
         last_caps_ff  <= last_caps_in;
         caps_lock_ff  <= caps_lock_in;
         tick_count_ff <= tick_count_in;
         square_ff     <= square_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_irq_request = rsp_irq_ff;
   assign rsp_caps_led    = caps_lock_ff;

endmodule

`default_nettype wire

[rtl/kmsp_decode.sv]
// Key matrix decoder: priority pick of the pressed key, table lookup, ctrl fold.
// Depends on kmsp_pkg.
`default_nettype none

module kmsp_decode (
   input  wire kmsp_pkg::rows_type rows,
   input  wire logic               caps_lock,
   output logic [7:0]              key_char
);

   logic [7:0] row_val;
   logic [7:0] cur_row;
   logic [3:0] row_sel;
   logic [2:0] bit_sel;
   logic       found;
   logic       shift_on;
   logic [6:0] tab_idx;
   logic [7:0] raw_char;
   logic       ctrl_on;
   logic       foldable;

   always_comb begin
      row_val = '0;
      cur_row = '0;
      row_sel = '0;
      found   = 1'b0;
      for (int r = kmsp_pkg::NUM_ROWS - 1; r >= 0; r--) begin
         cur_row = (r == kmsp_pkg::SHIFT_ROW) ? (rows[r] & kmsp_pkg::ROW8_KEY_MASK) : rows[r];
         if (cur_row != 8'h00) begin
            found   = 1'b1;
            row_sel = 4'(r);
            row_val = cur_row;
         end
      end
   end

   always_comb begin
      bit_sel = '0;
      for (int b = 7; b >= 0; b--) begin
         if (row_val[b]) begin
            bit_sel = 3'(b);
         end
      end
   end

   assign tab_idx  = {row_sel, bit_sel};
   assign shift_on = |(rows[kmsp_pkg::SHIFT_ROW] & kmsp_pkg::SHIFT_MASK);

   always_comb begin
      if (!found) begin
         raw_char = 8'h00;
      end else if (shift_on) begin
         raw_char = kmsp_pkg::TAB_SHIFT[tab_idx];
      end else if (caps_lock) begin
         raw_char = kmsp_pkg::TAB_CAPS[tab_idx];
      end else begin
         raw_char = kmsp_pkg::TAB_PLAIN[tab_idx];
      end
   end

   assign ctrl_on  = rows[kmsp_pkg::CTRL_ROW][kmsp_pkg::CTRL_BIT];
   assign foldable = ((raw_char >= kmsp_pkg::UPPER_LO) && (raw_char <= kmsp_pkg::UPPER_HI)) ||
                     ((raw_char >= kmsp_pkg::LOWER_LO) && (raw_char <= kmsp_pkg::LOWER_HI));
   assign key_char = (ctrl_on && foldable) ? (raw_char & kmsp_pkg::CTRL_MASK) : raw_char;

endmodule

`default_nettype wire

[rtl/kmsp_ring.sv]
// Character ring: memory with write and read pointers, registered head read.
// Depends on kmsp_pkg for the control and status structs.
`default_nettype none

module kmsp_ring #(
   parameter int RING_DEPTH = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire kmsp_pkg::ring_ctl_type  ring_ctl,
   output kmsp_pkg::ring_stat_type      ring_stat
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   logic [7:0]       mem [RING_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [7:0]       head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ring_ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ring_ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Keep the head register tracking mem[rd_ptr], forwarding a same-address write.
   always_ff @(posedge clock) begin
      if (ring_ctl.push) begin
         mem[wr_ptr_ff] <= ring_ctl.push_data;
      end
      if (ring_ctl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= ring_ctl.push_data;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign ring_stat.avail = (rd_ptr_ff != wr_ptr_ff);
   assign ring_stat.head  = head_ff;

endmodule

`default_nettype wire

[rtl/kmsp_checker.sv]
// Port-level checker for the keyboard serial port, bound to the top level.
// Depends on key_matrix_serial_port_macros.svh and key_matrix_serial_port.
`default_nettype none
`include "key_matrix_serial_port_macros.svh"

module kmsp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_irq_request
);

   `KMSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `KMSP_ASSERT_NOW(a_irq_no_data, clock, reset, rsp_valid && rsp_irq_request, rsp_read_data == 8'h00)
   `KMSP_ASSERT_NEXT(a_transfer_reaches_out, clock, reset, req_valid && req_ready, ##1 rsp_valid)
   `KMSP_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)

endmodule

bind key_matrix_serial_port kmsp_checker u_kmsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_data   (rsp_read_data),
   .rsp_irq_request (rsp_irq_request)
);

`default_nettype wire
